>>> sv/iwa_pkg.sv
// Shared types and constants for the interval weight accumulator.
package iwa_pkg;

    localparam int IDX_W    = 7;   // left_end, right_end and the count register
    localparam int POS_W    = 6;   // emitted position index
    localparam int WEIGHT_W = 32;  // signed Q16.16 weight
    localparam int SUM_W    = 48;  // signed Q32.16 saturated sum

    localparam logic [IDX_W-1:0] COUNT_RESET = 7'd64;

    // Address counter operations driven by the controller
    typedef enum logic [1:0] {
        ADDR_HOLD,
        ADDR_LEFT,
        ADDR_ZERO,
        ADDR_STEP
    } iwa_addr_op_t;

    typedef struct packed {
        logic         load;       // capture the incoming interval word
        iwa_addr_op_t addr_op;    // address counter operation
        logic         rd_en;      // read the store at the current address
        logic         update;     // the read feeds a saturating write-back
        logic         clear_all;  // drop every stored sum
    } iwa_cmd_t;

    typedef struct packed {
        logic range_empty;     // captured interval covers no position
        logic at_update_end;   // address is the last covered position
        logic at_emit_end;     // address is the last position to emit
    } iwa_status_t;

endpackage

>>> sv/iwa_ctrl.sv
// Controller state machine: sequences updates and emission of position sums.
module iwa_ctrl
    import iwa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        last_interval,
    input  logic        out_ready,
    input  iwa_status_t status,
    output logic        in_ready,
    output logic        out_valid,
    output iwa_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DRAIN,
        ST_EMIT_RD,
        ST_EMIT_SHOW
    } state_t;

    state_t state_reg, state_next;
    logic   last_reg, last_next;

    always_comb
    begin
        state_next    = state_reg;
        last_next     = last_reg;
        cmd           = '0;
        cmd.addr_op   = ADDR_HOLD;
        in_ready      = 1'b0;
        out_valid     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load    = 1'b1;
                    cmd.addr_op = ADDR_LEFT;
                    last_next   = last_interval;
                    state_next  = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (status.range_empty)
                begin
                    if (last_reg)
                    begin
                        cmd.addr_op = ADDR_ZERO;
                        state_next  = ST_EMIT_RD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.update = 1'b1;
                    if (status.at_update_end)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        cmd.addr_op = ADDR_STEP;
                    end
                end
            end
            ST_DRAIN:
            begin
                // the final write-back lands during this cycle
                if (last_reg)
                begin
                    cmd.addr_op = ADDR_ZERO;
                    state_next  = ST_EMIT_RD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_EMIT_SHOW;
            end
            ST_EMIT_SHOW:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (status.at_emit_end)
                    begin
                        cmd.clear_all = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        cmd.addr_op = ADDR_STEP;
                        state_next  = ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            last_reg  <= last_next;
        end
    end

endmodule

>>> sv/iwa_datapath.sv
// Datapath: sum store, address counter, saturating adder and count register.
module iwa_datapath
    import iwa_pkg::*;
#(
    parameter int MAX_POSITIONS = 64
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  iwa_cmd_t                   cmd,
    input  logic [IDX_W-1:0]           left_end,
    input  logic [IDX_W-1:0]           right_end,
    input  logic signed [WEIGHT_W-1:0] weight,
    input  logic                       cfg_wr,
    input  logic [IDX_W-1:0]           cfg_data,
    output iwa_status_t                status,
    output logic [POS_W-1:0]           position,
    output logic signed [SUM_W-1:0]    sum
);

    localparam int AW = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
    localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_POSITIONS);

    logic signed [SUM_W-1:0]    mem [MAX_POSITIONS];
    logic [MAX_POSITIONS-1:0]   vld_reg;

    logic [IDX_W-1:0]           left_reg, end_reg, addr_reg, addr_next;
    logic [IDX_W-1:0]           count_reg, count_eff;
    logic signed [WEIGHT_W-1:0] weight_reg;
    logic signed [SUM_W-1:0]    mem_q_reg, acc, wr_data;
    logic                       vld_q_reg;
    logic                       wr_en_reg;
    logic [AW-1:0]              wr_addr_reg;
    logic signed [SUM_W:0]      raw_sum;

    // Count register, clamped into 1 .. MAX_POSITIONS on use
    always_comb
    begin
        if (count_reg == '0)
        begin
            count_eff = IDX_W'(1);
        end
        else if (count_reg > MAX_IDX)
        begin
            count_eff = MAX_IDX;
        end
        else
        begin
            count_eff = count_reg;
        end
    end

    always_comb
    begin
        case (cmd.addr_op)
            ADDR_HOLD: addr_next = addr_reg;
            ADDR_LEFT: addr_next = left_end;
            ADDR_ZERO: addr_next = '0;
            ADDR_STEP: addr_next = addr_reg + IDX_W'(1);
            default:   addr_next = addr_reg;
        endcase
    end

    assign status.range_empty   = (left_reg >= end_reg);
    assign status.at_update_end = (addr_reg == end_reg - IDX_W'(1));
    assign status.at_emit_end   = (addr_reg == count_eff - IDX_W'(1));

    // Entries never written since the last clear read as zero
    assign acc     = vld_q_reg ? mem_q_reg : '0;
    assign raw_sum = {acc[SUM_W-1], acc} + (SUM_W+1)'(weight_reg);

    always_comb
    begin
        if (raw_sum[SUM_W] != raw_sum[SUM_W-1])
        begin
            wr_data = raw_sum[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
        else
        begin
            wr_data = raw_sum[SUM_W-1:0];
        end
    end

    assign position = addr_reg[POS_W-1:0];
    assign sum      = acc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg  <= '0;
            count_reg <= COUNT_RESET;
            vld_reg   <= '0;
            vld_q_reg <= 1'b0;
            wr_en_reg <= 1'b0;
        end
        else
        begin
            addr_reg  <= addr_next;
            wr_en_reg <= cmd.rd_en & cmd.update;
            if (cfg_wr)
            begin
                count_reg <= cfg_data;
            end
            if (cmd.rd_en)
            begin
                vld_q_reg <= vld_reg[addr_reg[AW-1:0]];
            end
            if (cmd.clear_all)
            begin
                vld_reg <= '0;
            end
            else if (wr_en_reg)
            begin
                vld_reg[wr_addr_reg] <= 1'b1;
            end
        end
    end

    // Interval capture; the end is clipped to the store depth
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            left_reg   <= left_end;
            end_reg    <= (right_end > MAX_IDX) ? MAX_IDX : right_end;
            weight_reg <= weight;
        end
        if (cmd.rd_en)
        begin
            wr_addr_reg <= addr_reg[AW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            mem_q_reg <= mem[addr_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en_reg)
        begin
            mem[wr_addr_reg] <= wr_data;
        end
    end

endmodule

>>> sv/interval_weight_accumulator_top.sv
// Top level of the interval weight accumulator.
// Each input word is one interval: every position k with left_end <= k < right_end
// (clipped to MAX_POSITIONS) gets the signed Q16.16 weight added to its 48-bit
// Q32.16 sum, saturating at each addition. A word marked last_interval is applied
// and then the sums of positions 0 .. count-1 are emitted in order, count being the
// configured number_of_positions forced into 1 .. MAX_POSITIONS, with last_position
// set on the final one; the store then reads as all zero again. Timing: after an
// accepted word, ST_UPDATE does one read-modify-write of the sum store per covered
// position, each write-back overlapping the next read, and ST_DRAIN lets the last
// write-back land; a word covering no position makes no store access. Each result
// word is read in ST_EMIT_RD, then held in ST_EMIT_SHOW until out_ready takes it.
// Clearing after emission is immediate through per-entry valid flags, so there is no
// clearing pass. The block serves one word at a time: in_ready is low throughout
// an update and an emission. cfg_data may be written while idle and is always ready.
module interval_weight_accumulator_top
    import iwa_pkg::*;
#(
    parameter int MAX_POSITIONS = 64
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [IDX_W-1:0]           left_end,
    input  logic [IDX_W-1:0]           right_end,
    input  logic signed [WEIGHT_W-1:0] weight,
    input  logic                       last_interval,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [POS_W-1:0]           position,
    output logic signed [SUM_W-1:0]    sum,
    output logic                       last_position,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [IDX_W-1:0]           cfg_data
);

    iwa_cmd_t    cmd;
    iwa_status_t status;

    // Count register takes a write on any cycle
    assign cfg_ready     = 1'b1;
    assign last_position = status.at_emit_end;

    iwa_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .last_interval (last_interval),
        .out_ready     (out_ready),
        .status        (status),
        .in_ready      (in_ready),
        .out_valid     (out_valid),
        .cmd           (cmd)
    );

    iwa_datapath #(
        .MAX_POSITIONS (MAX_POSITIONS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .left_end  (left_end),
        .right_end (right_end),
        .weight    (weight),
        .cfg_wr    (cfg_valid & cfg_ready),
        .cfg_data  (cfg_data),
        .status    (status),
        .position  (position),
        .sum       (sum)
    );

endmodule

>>> sv/iwa_checker.sv
// Port-level checker for the interval weight accumulator, bound to the top level.
module iwa_checker
    import iwa_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [POS_W-1:0]  position,
    input logic [SUM_W-1:0]  sum,
    input logic              last_position
);

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(position) && $stable(sum))
        else $error("result word changed while stalled");

    // Never take an interval while emitting
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready during emission");

    // Drop out of emission after the final position
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last_position |=> !out_valid && in_ready)
        else $error("emission did not end after final position");

    // Keep the input side closed after an accepted word
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted on consecutive cycles");

    // Advance the position by one between emitted words
    a_position_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_position |=> ##1 out_valid
            && position == $past(position, 2) + POS_W'(1))
        else $error("emitted position did not advance by one");

endmodule

bind interval_weight_accumulator_top iwa_checker u_iwa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .position      (position),
    .sum           (sum),
    .last_position (last_position)
);
